FILE: hdl/brlp_pkg.sv
// Shared types and constants for the board record line parser.
package brlp_pkg;

    localparam int BOARD_SQUARES = 64;
    localparam int SQ_IDX_W      = $clog2(BOARD_SQUARES);
    localparam int BCOUNT_W      = $clog2(BOARD_SQUARES + 2);
    localparam int SEPS_PER_REC  = 4;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_NL   = 8'h0A;
    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_B    = 8'h62;
    localparam logic [7:0] CH_W    = 8'h77;
    localparam logic [7:0] CH_DOT  = 8'h2E;

    localparam logic [2:0] FLD_ID     = 3'd0;
    localparam logic [2:0] FLD_BOARD  = 3'd1;
    localparam logic [2:0] FLD_PLAYER = 3'd2;

    localparam logic [1:0] KIND_ID      = 2'd0;
    localparam logic [1:0] KIND_DESC    = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_NONE        = 3'd1;
    localparam logic [2:0] ST_INCOMPLETE  = 3'd2;
    localparam logic [2:0] ST_BOARD_LEN   = 3'd3;
    localparam logic [2:0] ST_BAD_SQUARE  = 3'd4;
    localparam logic [2:0] ST_PLAYER_LEN  = 3'd5;
    localparam logic [2:0] ST_BAD_PLAYER  = 3'd6;

    typedef logic [BOARD_SQUARES-1:0] t_mask;

    typedef struct packed {
        logic [7:0] char_in;
        logic       line_last;
    } t_in_word;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [7:0] text_char;
        logic [2:0] line_status;
        t_mask      black_squares;
        t_mask      white_squares;
        logic       white_to_move;
        logic       last_of_item;
    } t_out_word;

    typedef struct packed {
        logic [1:0] cnt;
        t_out_word  first;
        t_out_word  second;
    } t_push;

endpackage

FILE: hdl/brlp_parse.sv
// Input register, per-line scan state and result word generation.
module brlp_parse (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  brlp_pkg::t_in_word i_in_word,
    input  logic              i_room,
    output brlp_pkg::t_push   o_push
);

    logic               r_in_valid;
    brlp_pkg::t_in_word r_in;

    logic [2:0]                       r_fields, n_fields;
    logic                             r_scan_over, n_scan_over;
    logic                             r_has, n_has;
    logic                             r_id, n_id;
    logic [brlp_pkg::BCOUNT_W-1:0]    r_bcount, n_bcount;
    brlp_pkg::t_mask                  r_black, n_black;
    brlp_pkg::t_mask                  r_white, n_white;
    logic                             r_sq_bad, n_sq_bad;
    logic [1:0]                       r_pcount, n_pcount;
    logic                             r_pwhite, n_pwhite;
    logic                             r_pbad, n_pbad;

    logic              go;
    logic              text_hit;
    logic [1:0]        text_kind;
    logic [2:0]        status;
    brlp_pkg::t_mask   sq_bit;
    brlp_pkg::t_out_word text_w, sum_w;

    assign go         = r_in_valid && i_room;
    assign o_in_stall = r_in_valid && !i_room;
    assign sq_bit     = brlp_pkg::t_mask'(1) << r_bcount[brlp_pkg::SQ_IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_word;
        end
    end

    always_comb begin
        n_fields    = r_fields;
        n_scan_over = r_scan_over;
        n_has       = r_has;
        n_id        = r_id;
        n_bcount    = r_bcount;
        n_black     = r_black;
        n_white     = r_white;
        n_sq_bad    = r_sq_bad;
        n_pcount    = r_pcount;
        n_pwhite    = r_pwhite;
        n_pbad      = r_pbad;
        text_hit    = 1'b0;
        text_kind   = brlp_pkg::KIND_ID;
        status      = brlp_pkg::ST_OK;

        if (!r_scan_over) begin
            if (r_in.char_in == brlp_pkg::CH_HASH || r_in.char_in == brlp_pkg::CH_NL
                    || r_in.char_in == brlp_pkg::CH_NUL) begin
                n_scan_over = 1'b1;
            end else if (r_in.char_in == brlp_pkg::CH_SEMI) begin
                n_has = 1'b1;
                if (r_fields < 3'(brlp_pkg::SEPS_PER_REC)) begin
                    n_fields = r_fields + 3'd1;
                end
                if (n_fields >= 3'(brlp_pkg::SEPS_PER_REC)) begin
                    n_scan_over = 1'b1;
                end
            end else begin
                n_has = 1'b1;
                case (r_fields)
                    brlp_pkg::FLD_ID: begin
                        n_id      = 1'b1;
                        text_hit  = 1'b1;
                        text_kind = brlp_pkg::KIND_ID;
                    end
                    brlp_pkg::FLD_BOARD: begin
                        if (r_bcount < brlp_pkg::BCOUNT_W'(brlp_pkg::BOARD_SQUARES)) begin
                            if (r_in.char_in == brlp_pkg::CH_B) begin
                                n_black = r_black | sq_bit;
                            end else if (r_in.char_in == brlp_pkg::CH_W) begin
                                n_white = r_white | sq_bit;
                            end else if (r_in.char_in != brlp_pkg::CH_DOT) begin
                                n_sq_bad = 1'b1;
                            end
                        end
                        if (r_bcount < brlp_pkg::BCOUNT_W'(brlp_pkg::BOARD_SQUARES + 1)) begin
                            n_bcount = r_bcount + brlp_pkg::BCOUNT_W'(1);
                        end
                    end
                    brlp_pkg::FLD_PLAYER: begin
                        if (r_pcount == 2'd0) begin
                            n_pwhite = (r_in.char_in == brlp_pkg::CH_W);
                            n_pbad   = (r_in.char_in != brlp_pkg::CH_W)
                                    && (r_in.char_in != brlp_pkg::CH_B);
                        end
                        if (r_pcount < 2'd2) begin
                            n_pcount = r_pcount + 2'd1;
                        end
                    end
                    default: begin
                        text_hit  = 1'b1;
                        text_kind = brlp_pkg::KIND_DESC;
                    end
                endcase
            end
        end

        if (!n_has) begin
            status = brlp_pkg::ST_NONE;
        end else if (n_fields != 3'(brlp_pkg::SEPS_PER_REC)) begin
            status = brlp_pkg::ST_INCOMPLETE;
        end else if (n_bcount != brlp_pkg::BCOUNT_W'(brlp_pkg::BOARD_SQUARES)) begin
            status = brlp_pkg::ST_BOARD_LEN;
        end else if (n_sq_bad) begin
            status = brlp_pkg::ST_BAD_SQUARE;
        end else if (n_pcount != 2'd1) begin
            status = brlp_pkg::ST_PLAYER_LEN;
        end else if (n_pbad) begin
            status = brlp_pkg::ST_BAD_PLAYER;
        end else if (!n_id) begin
            status = brlp_pkg::ST_NONE;
        end

        text_w               = '0;
        text_w.result_kind   = text_kind;
        text_w.text_char     = r_in.char_in;
        text_w.last_of_item  = !r_in.line_last;

        sum_w                = '0;
        sum_w.result_kind    = brlp_pkg::KIND_SUMMARY;
        sum_w.line_status    = status;
        sum_w.last_of_item   = 1'b1;
        if (status == brlp_pkg::ST_OK) begin
            sum_w.black_squares = n_black;
            sum_w.white_squares = n_white;
            sum_w.white_to_move = n_pwhite;
        end

        o_push.cnt    = go ? (2'(text_hit) + 2'(r_in.line_last)) : 2'd0;
        o_push.first  = text_hit ? text_w : sum_w;
        o_push.second = sum_w;

        // line end clears the scan state
        if (r_in.line_last) begin
            n_fields    = '0;
            n_scan_over = 1'b0;
            n_has       = 1'b0;
            n_id        = 1'b0;
            n_bcount    = '0;
            n_black     = '0;
            n_white     = '0;
            n_sq_bad    = 1'b0;
            n_pcount    = '0;
            n_pwhite    = 1'b0;
            n_pbad      = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fields    <= '0;
            r_scan_over <= 1'b0;
            r_has       <= 1'b0;
            r_id        <= 1'b0;
            r_bcount    <= '0;
            r_black     <= '0;
            r_white     <= '0;
            r_sq_bad    <= 1'b0;
            r_pcount    <= '0;
            r_pwhite    <= 1'b0;
            r_pbad      <= 1'b0;
        end else if (go) begin
            r_fields    <= n_fields;
            r_scan_over <= n_scan_over;
            r_has       <= n_has;
            r_id        <= n_id;
            r_bcount    <= n_bcount;
            r_black     <= n_black;
            r_white     <= n_white;
            r_sq_bad    <= n_sq_bad;
            r_pcount    <= n_pcount;
            r_pwhite    <= n_pwhite;
            r_pbad      <= n_pbad;
        end
    end

endmodule

FILE: hdl/brlp_outq.sv
// Result word queue: up to two words pushed per cycle, one popped unless the output stalls.
module brlp_outq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  brlp_pkg::t_push     i_push,
    output logic                o_room,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output brlp_pkg::t_out_word o_out_word
);

    brlp_pkg::t_out_word r_mem [brlp_pkg::QUEUE_DEPTH];
    logic [brlp_pkg::QPTR_W-1:0] r_wr, n_wr;
    logic [brlp_pkg::QPTR_W-1:0] r_rd, n_rd;
    logic [brlp_pkg::QCNT_W-1:0] r_count, n_count;
    logic                        pop;

    assign o_out_valid = (r_count != '0);
    assign o_out_word  = r_mem[r_rd];
    assign o_room      = (r_count <= brlp_pkg::QCNT_W'(brlp_pkg::QUEUE_DEPTH - 2));
    assign pop         = o_out_valid && !i_out_stall;

    always_comb begin
        n_wr    = r_wr + brlp_pkg::QPTR_W'(i_push.cnt);
        n_rd    = r_rd + brlp_pkg::QPTR_W'(pop);
        n_count = r_count + brlp_pkg::QCNT_W'(i_push.cnt) - brlp_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr] <= i_push.first;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[r_wr + brlp_pkg::QPTR_W'(1)] <= i_push.second;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= brlp_pkg::QCNT_W'(brlp_pkg::QUEUE_DEPTH))
        else $error("result queue overflow");

    a_push_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.cnt != 2'd0) |-> o_room)
        else $error("push without room");

    a_pair_ends_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.cnt == 2'd2) |-> (i_push.second.result_kind == brlp_pkg::KIND_SUMMARY
            && !i_push.first.last_of_item && i_push.second.last_of_item))
        else $error("bad word pair");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && i_push.cnt == 2'd0 && r_count == brlp_pkg::QCNT_W'(1)) |=> !o_out_valid)
        else $error("queue did not drain");
`endif

endmodule

FILE: hdl/board_record_line_parser.sv
// Top level: record line parser, one text byte per input word.
// An accepted word waits in the input register until its result words enter the queue.
// The parser takes one input word per cycle while results drain; a line-ending id or
// description byte gives two result words, leaving one per cycle unless stalled.
// The parse stage advances only with room for two words in the 4-entry queue.
// Reset (synchronous, active low) empties the queue and clears the line state.
module board_record_line_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  brlp_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output brlp_pkg::t_out_word o_out_word
);

    brlp_pkg::t_push push;
    logic            room;

    brlp_parse u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .i_room     (room),
        .o_push     (push)
    );

    brlp_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_room      (room),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule
